@@ design/mccs_pkg.sv @@
// ----------------------------------------------------------------------------
// mccs_pkg
// Shared types and constants for the context count sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package mccs_pkg;

  localparam int BUCKETS_DEF    = 16;
  localparam int COUNT_BITS_DEF = 32;
  localparam int SEL_W          = 4;
  localparam int FRAC_W         = 16;
  localparam int TOTAL_W        = 36;
  localparam int BCOUNT_W       = 5;

  localparam logic [BCOUNT_W-1:0] BCOUNT_RESET = 5'd16;

  localparam logic ACT_RECORD = 1'b0;
  localparam logic ACT_DRAW   = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_REC_RD,
    ST_REC_WR,
    ST_SUM,
    ST_MUL,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

@@ design/markov_context_count_sampler_unit.sv @@
// ----------------------------------------------------------------------------
// markov_context_count_sampler_unit
// Transition count table with record (saturating increment) and weighted
// draw over one (left, above) context, one shared adder under a sequencer.
// ----------------------------------------------------------------------------
// Record: the cell is read, then written back with its saturating increment.
// Draw: sum pass, 16-step multiply, then a walk pass that stops at the picked bucket
//   or at the last of the buckets in use; each pass makes one table read per cycle.
// One request at a time: the input is taken again only once the result is loaded.
// Reset: synchronous; a clearing pass loads the table, with the input stalled and
//   config writes still taken.
`default_nettype none

module markov_context_count_sampler_unit #(
  parameter int BUCKETS    = mccs_pkg::BUCKETS_DEF,
  parameter int COUNT_BITS = mccs_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output      logic                          in_stall,
  input  wire logic                          action,
  input  wire logic [mccs_pkg::SEL_W-1:0]    left_bucket,
  input  wire logic [mccs_pkg::SEL_W-1:0]    above_bucket,
  input  wire logic [mccs_pkg::SEL_W-1:0]    center_bucket,
  input  wire logic [mccs_pkg::FRAC_W-1:0]   random_fraction,
  output      logic                          out_valid,
  input  wire logic                          out_stall,
  output      logic [mccs_pkg::SEL_W-1:0]    next_bucket,
  output      logic [mccs_pkg::TOTAL_W-1:0]  context_total,
  input  wire logic                          cfg_valid,
  output      logic                          cfg_ready,
  input  wire logic [mccs_pkg::BCOUNT_W-1:0] cfg_data
);
  import mccs_pkg::*;

  localparam int BW    = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW    = BW + 1;
  localparam int AB    = 3 * BW;
  localparam int DEPTH = 1 << AB;
  localparam int TW    = COUNT_BITS + BW;
  localparam int AW    = TW + FRAC_W + 1;
  localparam int XW    = (TW > TOTAL_W) ? TW : TOTAL_W;

  localparam logic [FRAC_W:0] ROUND_ONE = 17'h18000;

  function automatic logic [BW-1:0] clamp(input logic [SEL_W-1:0] v);
    if (32'(v) >= BUCKETS) begin
      return BW'(BUCKETS - 1);
    end
    return BW'(v);
  endfunction

  state_t state, state_next;

  logic [COUNT_BITS-1:0] mem [DEPTH];
  logic [COUNT_BITS-1:0] rdata;
  logic [AB-1:0]         mem_raddr;
  logic [AB-1:0]         mem_waddr;
  logic [COUNT_BITS-1:0] mem_wdata;
  logic                  mem_we;

  logic [BCOUNT_W-1:0] bucket_count;
  logic [NW-1:0]       n_use;

  logic [AB-1:0]     clr_addr;
  logic [BW-1:0]     l_q, a_q, c_q;
  logic              draw_q;
  logic [FRAC_W-1:0] r_q;
  logic [FRAC_W-1:0] rsh;
  logic [NW-1:0]     idx;
  logic              rd_pend;
  logic [BW-1:0]     rd_idx;
  logic [AW-1:0]     acc;
  logic [AW-1:0]     mcand;
  logic [TW-1:0]     total_q;
  logic [3:0]        mstep;
  logic [BW-1:0]     pick;
  logic [XW-1:0]     total_ext;

  logic [AW-1:0] add_a, add_b, add_sum;
  logic          add_cin;

  logic accept, issue, sum_done, walk_hit, walk_last, out_load, clr_last, rec_full;

  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign add_sum   = add_a + add_b + AW'(add_cin);
  assign issue     = ((state == ST_SUM) || (state == ST_WALK)) && (idx < n_use);
  assign sum_done  = (idx >= n_use) && !rd_pend;
  assign walk_hit  = add_sum[AW-1] || (add_sum == '0);
  assign walk_last = {1'b0, rd_idx} == (n_use - NW'(1));
  assign out_load  = (state == ST_DONE) && (!out_valid || !out_stall);
  assign clr_last  = clr_addr == '1;
  assign rec_full  = rdata == '1;
  assign total_ext = XW'(total_q);

  always_comb begin
    if (bucket_count == '0) begin
      n_use = NW'(1);
    end else if (32'(bucket_count) > BUCKETS) begin
      n_use = NW'(BUCKETS);
    end else begin
      n_use = NW'(bucket_count);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_last) state_next = ST_IDLE;
      ST_IDLE: begin
        if (accept) state_next = (action == ACT_DRAW) ? ST_SUM : ST_REC_RD;
      end
      ST_REC_RD: state_next = ST_REC_WR;
      ST_REC_WR: state_next = ST_DONE;
      ST_SUM: begin
        if (sum_done) state_next = (acc == '0) ? ST_DONE : ST_MUL;
      end
      ST_MUL: if (mstep == 4'hF) state_next = ST_WALK;
      ST_WALK: if (rd_pend && (walk_hit || walk_last)) state_next = ST_DONE;
      ST_DONE: if (out_load) state_next = ST_IDLE;
      default: state_next = ST_CLEAR;
    endcase
  end

  // outputs and shared adder operands
  always_comb begin
    in_stall  = 1'b1;
    mem_we    = 1'b0;
    mem_waddr = {l_q, a_q, c_q};
    mem_wdata = rdata;
    mem_raddr = {l_q, a_q, idx[BW-1:0]};
    add_a     = acc;
    add_b     = AW'(rdata);
    add_cin   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr;
        mem_wdata = (clr_addr[BW-1:0] == '0) ? COUNT_BITS'(1) : '0;
      end
      ST_IDLE: in_stall = 1'b0;
      ST_REC_RD: mem_raddr = {l_q, a_q, c_q};
      ST_REC_WR: begin
        add_a     = AW'(rdata);
        add_b     = '0;
        add_cin   = 1'b1;
        mem_we    = 1'b1;
        mem_wdata = rec_full ? rdata : add_sum[COUNT_BITS-1:0];
      end
      ST_SUM: ;
      ST_MUL: add_b = rsh[0] ? mcand : '0;
      ST_WALK: begin
        add_b   = ~AW'(rdata);
        add_cin = 1'b1;
      end
      ST_DONE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      bucket_count <= BCOUNT_RESET;
      out_valid    <= 1'b0;
      rd_pend      <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        bucket_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_CLEAR: clr_addr <= clr_addr + AB'(1);
        ST_SUM, ST_WALK: rd_pend <= issue;
        default: rd_pend <= 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      idx    <= idx + NW'(1);
      rd_idx <= idx[BW-1:0];
    end
    if (out_load) begin
      next_bucket   <= draw_q ? SEL_W'(pick) : '0;
      context_total <= draw_q ? total_ext[TOTAL_W-1:0] : '0;
    end
    unique case (state)
      ST_IDLE: begin
        l_q    <= clamp(left_bucket);
        a_q    <= clamp(above_bucket);
        c_q    <= clamp(center_bucket);
        draw_q <= action;
        r_q    <= random_fraction;
        idx    <= '0;
        acc    <= '0;
        pick   <= '0;
      end
      ST_SUM: begin
        if (rd_pend) begin
          acc <= add_sum;
        end
        if (sum_done) begin
          total_q <= acc[TW-1:0];
          mcand   <= AW'(acc[TW-1:0]);
          acc     <= AW'(ROUND_ONE - {1'b0, r_q});
          rsh     <= r_q;
          mstep   <= '0;
        end
      end
      ST_MUL: begin
        mcand <= mcand << 1;
        rsh   <= rsh >> 1;
        mstep <= mstep + 4'd1;
        if (mstep == 4'hF) begin
          acc <= add_sum >> FRAC_W;
          idx <= '0;
        end else begin
          acc <= add_sum;
        end
      end
      ST_WALK: begin
        if (rd_pend) begin
          if (walk_hit || walk_last) begin
            pick <= rd_idx;
          end else begin
            acc <= add_sum;
          end
        end
      end
      ST_CLEAR, ST_REC_RD, ST_REC_WR, ST_DONE: ;
      default: ;
    endcase
  end

endmodule

`default_nettype wire

@@ design/mccs_checker.sv @@
// ----------------------------------------------------------------------------
// mccs_checker
// Port-level checks for the context count sampler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mccs_checker (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         in_valid,
  input wire logic                         in_stall,
  input wire logic                         out_valid,
  input wire logic                         out_stall,
  input wire logic [mccs_pkg::SEL_W-1:0]   next_bucket,
  input wire logic [mccs_pkg::TOTAL_W-1:0] context_total
);
  import mccs_pkg::*;

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(next_bucket) && $stable(context_total))
    else $error("result changed while stalled");

  // one request at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while busy");

  // a result only appears while a request is in progress
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result without request");

endmodule

bind markov_context_count_sampler_unit mccs_checker u_mccs_checker (.*);

`default_nettype wire

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the context count sampler: records and draws are
// driven with random idling on both sides, each result is compared with a
// local copy of the count table and the weighted draw it implies.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import mccs_pkg::*;

  localparam int CELLS      = 4096;
  localparam int LIMIT      = 400000;
  localparam int PHASE_REQS = 120;
  localparam int PHASES     = 6;

  typedef struct {
    logic                act;
    logic [SEL_W-1:0]    left;
    logic [SEL_W-1:0]    above;
    logic [SEL_W-1:0]    center;
    logic [FRAC_W-1:0]   frac;
  } request_t;

  typedef struct {
    logic [SEL_W-1:0]    bucket;
    logic [TOTAL_W-1:0]  total;
  } outcome_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic                action;
  logic [SEL_W-1:0]    left_bucket;
  logic [SEL_W-1:0]    above_bucket;
  logic [SEL_W-1:0]    center_bucket;
  logic [FRAC_W-1:0]   random_fraction;
  logic                out_valid;
  logic                out_stall;
  logic [SEL_W-1:0]    next_bucket;
  logic [TOTAL_W-1:0]  context_total;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [BCOUNT_W-1:0] cfg_data;

  bit [31:0]           tally [CELLS];
  logic [BCOUNT_W-1:0] model_bcount;
  outcome_t            pending_outcomes [$];

  bit          quiet;
  int unsigned cycles;
  int unsigned errors;
  int unsigned n_records;
  int unsigned n_draws;
  int unsigned n_cfg;
  int unsigned n_checked;

  markov_context_count_sampler_unit dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .action          (action),
    .left_bucket     (left_bucket),
    .above_bucket    (above_bucket),
    .center_bucket   (center_bucket),
    .random_fraction (random_fraction),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .next_bucket     (next_bucket),
    .context_total   (context_total),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("%0t timeout after %0d cycles, %0d results outstanding", $realtime, cycles,
               pending_outcomes.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // ---- table model --------------------------------------------------------

  function automatic void clear_tally();
    for (int k = 0; k < CELLS; k++) begin
      tally[k] = (k[3:0] == 4'd0) ? 32'd1 : 32'd0;
    end
    model_bcount = BCOUNT_RESET;
  endfunction

  function automatic int unsigned live_buckets();
    if (model_bcount == '0) return 1;
    if (model_bcount > 5'd16) return 16;
    return 32'(model_bcount);
  endfunction

  function automatic outcome_t tally_and_draw(request_t req);
    outcome_t    res;
    int unsigned n;
    int unsigned i;
    logic [63:0] total;
    logic [63:0] span;
    logic [63:0] roll;
    logic [63:0] cnt;
    res.bucket = '0;
    res.total  = '0;
    if (req.act == ACT_RECORD) begin
      if (tally[{req.left, req.above, req.center}] != 32'hFFFF_FFFF)
        tally[{req.left, req.above, req.center}]++;
      return res;
    end
    n = live_buckets();
    total = '0;
    for (i = 0; i < n; i++) total += 64'(tally[{req.left, req.above, SEL_W'(i)}]);
    if (total == 64'd0) return res;
    span = total - 64'd1;
    roll = 64'd1 + ((span * {48'd0, req.frac} + 64'd32768) >> 16);
    i = 0;
    while (roll > 0 && i < n) begin
      cnt = 64'(tally[{req.left, req.above, SEL_W'(i)}]);
      if (cnt >= roll) roll = 0;
      else roll -= cnt;
      i++;
    end
    res.bucket = SEL_W'(i - 1);
    res.total  = total[TOTAL_W-1:0];
    return res;
  endfunction

  // ---- request side -------------------------------------------------------

  task automatic send_req(input logic act, input int unsigned l, input int unsigned a,
                          input int unsigned c, input int unsigned r);
    request_t req;
    req.act    = act;
    req.left   = SEL_W'(l);
    req.above  = SEL_W'(a);
    req.center = SEL_W'(c);
    req.frac   = FRAC_W'(r);
    in_valid        <= 1'b1;
    action          <= req.act;
    left_bucket     <= req.left;
    above_bucket    <= req.above;
    center_bucket   <= req.center;
    random_fraction <= req.frac;
    do @(posedge clk); while (in_stall);
    pending_outcomes.push_back(tally_and_draw(req));
    if (act == ACT_RECORD) n_records++;
    else n_draws++;
  endtask

  task automatic hold_off(input int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_bcount(input logic [BCOUNT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_bcount = value;
    n_cfg++;
  endtask

  // ---- result side --------------------------------------------------------

  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!quiet && $urandom_range(0, 9) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 15)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t unexpected result: bucket %0d total %0d", $realtime, next_bucket,
                 context_total);
      end else begin
        want = pending_outcomes.pop_front();
        n_checked++;
        if (next_bucket !== want.bucket) begin
          errors++;
          if (errors < 60)
            $display("%0t next_bucket mismatch: expected %0d actual %0d", $realtime,
                     want.bucket, next_bucket);
        end
        if (context_total !== want.total) begin
          errors++;
          if (errors < 60)
            $display("%0t context_total mismatch: expected %0d actual %0d", $realtime,
                     want.total, context_total);
        end
      end
    end
  end

  // ---- tests --------------------------------------------------------------

  // fresh table: every context holds a single count at centre 0
  task automatic test_reset_table();
    send_req(ACT_DRAW, 0, 0, 0, 0);
    send_req(ACT_DRAW, 15, 15, 9, 16'hFFFF);
    send_req(ACT_DRAW, 5, 10, 0, 16'h8000);
    settle_idle();
  endtask

  task automatic test_record_and_walk();
    send_req(ACT_RECORD, 15, 15, 15, 16'hFFFF);
    send_req(ACT_RECORD, 15, 15, 15, 0);
    send_req(ACT_RECORD, 15, 15, 7, 0);
    send_req(ACT_RECORD, 0, 0, 0, 16'h1234);
    send_req(ACT_DRAW, 15, 15, 0, 0);
    send_req(ACT_DRAW, 15, 15, 0, 16'hFFFF);
    send_req(ACT_DRAW, 15, 15, 0, 16'h8000);
    send_req(ACT_DRAW, 0, 0, 15, 16'hFFFF);
    settle_idle();
  endtask

  // zero acts as one, above sixteen acts as sixteen
  task automatic test_bucket_count();
    write_bcount(5'd0);
    send_req(ACT_DRAW, 15, 15, 0, 16'hFFFF);
    settle_idle();
    write_bcount(5'd8);
    send_req(ACT_DRAW, 15, 15, 0, 16'hFFFF);
    settle_idle();
    write_bcount(5'd31);
    send_req(ACT_DRAW, 15, 15, 0, 16'hFFFF);
    settle_idle();
    write_bcount(5'd17);
    send_req(ACT_DRAW, 15, 15, 0, 16'hC000);
    settle_idle();
    write_bcount(5'd1);
    send_req(ACT_DRAW, 0, 0, 0, 16'h7FFF);
    settle_idle();
    write_bcount(5'd16);
    settle_idle();
  endtask

  // most traffic lands on a few hot contexts so counts and walks grow long
  task automatic test_random_traffic();
    int unsigned hot_l [4];
    int unsigned hot_a [4];
    int unsigned hot_c [4];
    int unsigned h;
    int unsigned l;
    int unsigned a;
    int unsigned c;
    int unsigned r;
    logic        act;
    for (int k = 0; k < 4; k++) begin
      hot_l[k] = $urandom_range(0, 15);
      hot_a[k] = $urandom_range(0, 15);
      hot_c[k] = $urandom_range(0, 15);
    end
    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0, 3, 5: write_bcount(5'd16);
        2:       write_bcount(5'd1);
        4:       write_bcount(BCOUNT_W'($urandom_range(2, 15)));
        default: write_bcount(BCOUNT_W'($urandom_range(0, 31)));
      endcase
      if (ph == PHASES - 1) quiet = 1'b1;
      for (int i = 0; i < PHASE_REQS; i++) begin
        if (!quiet && $urandom_range(0, 7) == 0) hold_off($urandom_range(1, 15));
        h = $urandom_range(0, 3);
        if ($urandom_range(0, 4) != 0) begin
          l = hot_l[h];
          a = hot_a[h];
        end else begin
          l = $urandom_range(0, 15);
          a = $urandom_range(0, 15);
        end
        c = ($urandom_range(0, 1) == 0) ? hot_c[h] : $urandom_range(0, 15);
        case ($urandom_range(0, 9))
          0:       r = 0;
          1:       r = 16'hFFFF;
          default: r = $urandom_range(0, 65535);
        endcase
        act = ($urandom_range(0, 99) < 55) ? ACT_RECORD : ACT_DRAW;
        send_req(act, l, a, c, r);
      end
      settle_idle();
    end
  endtask

  initial begin
    rst             = 1'b1;
    in_valid        = 1'b0;
    action          = ACT_RECORD;
    left_bucket     = '0;
    above_bucket    = '0;
    center_bucket   = '0;
    random_fraction = '0;
    cfg_valid       = 1'b0;
    cfg_data        = '0;
    quiet           = 1'b0;
    cycles          = 0;
    errors          = 0;
    n_records       = 0;
    n_draws         = 0;
    n_cfg           = 0;
    n_checked       = 0;
    clear_tally();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_table();
    test_record_and_walk();
    test_bucket_count();
    test_random_traffic();

    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("Covered %0d records and %0d weighted draws over %0d bucket count writes,",
             n_records, n_draws, n_cfg);
    $display("with %0d results checked under random idling on both sides.", n_checked);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
